// File: src/csv_row_field_parser_macros.svh
// assertion helpers for the csv row/field parser
`ifndef CSV_ROW_FIELD_PARSER_MACROS_SVH
`define CSV_ROW_FIELD_PARSER_MACROS_SVH

// same-cycle implication, disabled during reset
`define CSVRF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define CSVRF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/csvrf_pkg.sv
package csvrf_pkg;

    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    // field counter saturates here (max fields, capped by the 8-bit count)
    localparam logic [7:0] FIELD_LIMIT = 8'd255;

    typedef enum logic [2:0] {
        ERR_NONE           = 3'd0,
        ERR_QUOTE_IN_FIELD = 3'd1,
        ERR_AFTER_QUOTE    = 3'd2,
        ERR_EOF_IN_QUOTES  = 3'd3,
        ERR_FIELD_COUNT    = 3'd4
    } err_code_t;

endpackage

// File: src/csv_row_field_parser.sv
// csv_row_field_parser: takes csv text one byte per word on the s_ side and
// emits one word on the m_ side per content byte, field end or row end.
// quoted fields ("..." with "" for a literal quote), leading blanks skipped,
// empty lines dropped, cr / lf / crlf end a row. a malformed row gives one
// word with row_end and an error code, then bytes are dropped up to the next
// line end. s_tlast marks end of text (byte ignored) and closes any open row.
// cfg_wdata sets the required field count per row (0 = any); write it only
// while the block is idle. rate: one byte per cycle sustained; each byte
// passes the input register, then the result register; the only thing that
// slows the flow is m_tready held low while a result waits, since words
// that give no result pass through regardless.
`include "csv_row_field_parser_macros.svh"

module csv_row_field_parser
    import csvrf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,     // expected_fields

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] byte_in
    input  logic        s_tlast,       // end_of_input

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,       // [7:0] data_byte, [15:8] field_count,
                                       // [18:16] error_code, [23:19] zero
    output logic [1:0]  m_tuser,       // [0] data_valid, [1] field_end
    output logic        m_tlast        // row_end
);

    // configuration
    logic [7:0] expected_reg;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // parser state
    logic       in_quotes_reg,      in_quotes_next;
    logic       quote_pending_reg,  quote_pending_next;
    logic       field_has_data_reg, field_has_data_next;
    logic       at_row_start_reg,   at_row_start_next;
    logic       swallow_lf_reg,     swallow_lf_next;
    logic       skip_to_eol_reg,    skip_to_eol_next;
    logic [7:0] fields_reg,         fields_next;

    // result register
    logic       out_valid_reg, out_valid_next;
    logic       out_dv_reg;
    logic [7:0] out_byte_reg;
    logic       out_fe_reg;
    logic       out_re_reg;
    logic [7:0] out_count_reg;
    err_code_t  out_err_reg;

    // result of the byte in the input register
    logic       res_valid;
    logic       res_dv;
    logic [7:0] res_byte;
    logic       res_fe;
    logic       res_re;
    logic [7:0] res_count;
    err_code_t  res_err;

    logic       advance;
    logic       out_free;
    logic       is_eol;
    logic [7:0] count_inc;
    logic       count_bad;
    logic       proceed;
    logic       row_clear;
    logic       row_abort;

    assign is_eol    = (in_byte_reg == CH_CR) || (in_byte_reg == CH_LF);
    assign count_inc = (fields_reg < FIELD_LIMIT) ? fields_reg + 8'd1 : fields_reg;
    assign count_bad = (expected_reg != 8'd0) && (count_inc != expected_reg);

    // byte handling: defaults hold state, the swallow flag lasts one byte
    always_comb begin
        res_valid = 1'b0;
        res_dv    = 1'b0;
        res_byte  = 8'd0;
        res_fe    = 1'b0;
        res_re    = 1'b0;
        res_count = fields_reg;
        res_err   = ERR_NONE;
        proceed   = 1'b0;
        row_clear = 1'b0;
        row_abort = 1'b0;

        in_quotes_next      = in_quotes_reg;
        quote_pending_next  = quote_pending_reg;
        field_has_data_next = field_has_data_reg;
        at_row_start_next   = at_row_start_reg;
        skip_to_eol_next    = skip_to_eol_reg;
        fields_next         = fields_reg;
        swallow_lf_next     = 1'b0;

        if (in_last_reg) begin
            // end of text closes the open row
            row_clear = 1'b1;
            if (skip_to_eol_reg || at_row_start_reg) begin
                res_valid = 1'b0;
            end else if (in_quotes_reg && !quote_pending_reg) begin
                res_valid = 1'b1;
                res_re    = 1'b1;
                res_err   = ERR_EOF_IN_QUOTES;
            end else begin
                res_valid = 1'b1;
                res_fe    = 1'b1;
                res_re    = 1'b1;
                res_count = count_inc;
                res_err   = count_bad ? ERR_FIELD_COUNT : ERR_NONE;
            end
        end else if (skip_to_eol_reg) begin
            // dropping the rest of a bad line
            if (is_eol) begin
                row_clear       = 1'b1;
                swallow_lf_next = (in_byte_reg == CH_CR);
            end
        end else begin
            proceed = 1'b1;
            if (at_row_start_reg) begin
                if (swallow_lf_reg && in_byte_reg == CH_LF) begin
                    proceed = 1'b0;
                end else if (in_byte_reg == CH_SPACE || in_byte_reg == CH_TAB) begin
                    proceed = 1'b0;
                end else if (is_eol) begin
                    proceed         = 1'b0;
                    swallow_lf_next = (in_byte_reg == CH_CR);
                end else begin
                    at_row_start_next = 1'b0;
                end
            end

            if (proceed) begin
                if (in_quotes_reg && !quote_pending_reg) begin
                    if (in_byte_reg == CH_QUOTE) begin
                        quote_pending_next = 1'b1;
                    end else begin
                        res_valid           = 1'b1;
                        res_dv              = 1'b1;
                        res_byte            = in_byte_reg;
                        field_has_data_next = 1'b1;
                    end
                end else if (in_byte_reg == CH_QUOTE) begin
                    if (in_quotes_reg) begin
                        // doubled quote inside a quoted field
                        quote_pending_next  = 1'b0;
                        res_valid           = 1'b1;
                        res_dv              = 1'b1;
                        res_byte            = in_byte_reg;
                        field_has_data_next = 1'b1;
                    end else if (!field_has_data_reg) begin
                        in_quotes_next = 1'b1;
                    end else begin
                        row_abort = 1'b1;
                        res_valid = 1'b1;
                        res_re    = 1'b1;
                        res_err   = ERR_QUOTE_IN_FIELD;
                    end
                end else if (in_byte_reg == CH_COMMA) begin
                    in_quotes_next      = 1'b0;
                    quote_pending_next  = 1'b0;
                    field_has_data_next = 1'b0;
                    fields_next         = count_inc;
                    res_valid           = 1'b1;
                    res_fe              = 1'b1;
                    res_count           = count_inc;
                end else if (is_eol) begin
                    row_clear       = 1'b1;
                    swallow_lf_next = (in_byte_reg == CH_CR);
                    res_valid       = 1'b1;
                    res_fe          = 1'b1;
                    res_re          = 1'b1;
                    res_count       = count_inc;
                    res_err         = count_bad ? ERR_FIELD_COUNT : ERR_NONE;
                end else if (in_quotes_reg) begin
                    // closing quote followed by something other than , or eol
                    row_abort = 1'b1;
                    res_valid = 1'b1;
                    res_re    = 1'b1;
                    res_err   = ERR_AFTER_QUOTE;
                end else begin
                    res_valid           = 1'b1;
                    res_dv              = 1'b1;
                    res_byte            = in_byte_reg;
                    field_has_data_next = 1'b1;
                end
            end
        end

        if (row_clear || row_abort) begin
            in_quotes_next      = 1'b0;
            quote_pending_next  = 1'b0;
            field_has_data_next = 1'b0;
            at_row_start_next   = 1'b1;
            skip_to_eol_next    = 1'b0;
            fields_next         = 8'd0;
        end
        if (row_abort) begin
            at_row_start_next = 1'b0;
            skip_to_eol_next  = 1'b1;
        end
    end

    // flow control: a word with no result never waits on the output
    assign out_free       = !out_valid_reg || m_tready;
    assign advance        = in_valid_reg && (!res_valid || out_free);
    assign s_tready       = !in_valid_reg || advance;
    assign out_valid_next = (out_valid_reg && !m_tready) || (advance && res_valid);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_reg       <= 8'd0;
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            in_quotes_reg      <= 1'b0;
            quote_pending_reg  <= 1'b0;
            field_has_data_reg <= 1'b0;
            at_row_start_reg   <= 1'b1;
            swallow_lf_reg     <= 1'b0;
            skip_to_eol_reg    <= 1'b0;
            fields_reg         <= 8'd0;
        end else begin
            if (cfg_we) begin
                expected_reg <= cfg_wdata;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            out_valid_reg <= out_valid_next;
            if (advance) begin
                in_quotes_reg      <= in_quotes_next;
                quote_pending_reg  <= quote_pending_next;
                field_has_data_reg <= field_has_data_next;
                at_row_start_reg   <= at_row_start_next;
                swallow_lf_reg     <= swallow_lf_next;
                skip_to_eol_reg    <= skip_to_eol_next;
                fields_reg         <= fields_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && res_valid) begin
            out_dv_reg    <= res_dv;
            out_byte_reg  <= res_byte;
            out_fe_reg    <= res_fe;
            out_re_reg    <= res_re;
            out_count_reg <= res_count;
            out_err_reg   <= res_err;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_err_reg, out_count_reg, out_byte_reg};
    assign m_tuser  = {out_fe_reg, out_dv_reg};
    assign m_tlast  = out_re_reg;

    // a content byte never carries a field or row end or an error
    `CSVRF_ASSERT_NOW(a_data_word_plain, m_tvalid && m_tuser[0],
        !m_tuser[1] && !m_tlast && m_tdata[18:16] == ERR_NONE,
        "content word carries end mark or error")

    // any error ends the row
    `CSVRF_ASSERT_NOW(a_error_ends_row, m_tvalid && m_tdata[18:16] != ERR_NONE, m_tlast,
        "error reported without row end")

    // while dropping a bad line no field is open
    `CSVRF_ASSERT_NOW(a_skip_state, skip_to_eol_reg,
        !in_quotes_reg && !at_row_start_reg && fields_reg == 8'd0,
        "inconsistent state while dropping a line")

    // end of text puts the parser back at row start
    `CSVRF_ASSERT_NEXT(a_eoi_resets_row, advance && in_last_reg,
        at_row_start_reg && !skip_to_eol_reg && !in_quotes_reg && fields_reg == 8'd0,
        "row state not cleared after end of text")

endmodule
